### design/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the track-chunk event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    localparam int VARLEN_BITS = 28;
    localparam int OUT_LEN_W   = 28;
    localparam int HDR_BYTES   = 8;
    localparam int HDR_CNT_W   = $clog2(HDR_BYTES);

    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] META_EOT      = 8'h2F;
    localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
    localparam logic [3:0] TYPE_CHAN_PRS = 4'hD;
    localparam logic [3:0] TYPE_BEND     = 4'hE;
    localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;

    localparam logic [3:0] KIND_META    = 4'd7;
    localparam logic [3:0] KIND_SYSEX   = 4'd8;
    localparam logic [3:0] KIND_PAYLOAD = 4'd9;

    typedef enum logic [8:0] {
        PH_HEADER  = 9'b000000001,
        PH_DELTA   = 9'b000000010,
        PH_STATUS  = 9'b000000100,
        PH_FIRST   = 9'b000001000,
        PH_SECOND  = 9'b000010000,
        PH_MTYPE   = 9'b000100000,
        PH_LENGTH  = 9'b001000000,
        PH_PAYLOAD = 9'b010000000,
        PH_SKIP    = 9'b100000000
    } t_phase;

    typedef logic [VARLEN_BITS-1:0] t_varlen;

    typedef struct packed {
        logic [3:0]           kind;
        logic [3:0]           channel_number;
        logic [7:0]           first_data;
        logic [7:0]           second_data;
        logic [15:0]          bend_value;
        logic [OUT_LEN_W-1:0] delta_ticks;
        logic [7:0]           meta_type;
        logic [OUT_LEN_W-1:0] payload_length;
        logic [7:0]           payload_byte;
        logic                 last_payload;
        logic                 end_of_track;
    } t_result;

    function automatic t_varlen varlen_shift(input t_varlen acc, input logic [7:0] b);
        return t_varlen'({acc, b[6:0]});
    endfunction

endpackage

### design/midi_track_event_parser_core.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_core
// Track-chunk byte parser: skips the chunk header, decodes delta times and
// channel, meta and sysex events with running status.
// ----------------------------------------------------------------------------
// Output: registered; a result appears on the master side in the cycle after
// the byte that completes it is accepted; bytes that complete nothing give no item.
// Throughput: one byte per cycle unless the master side stalls; the byte-wise parse
// state updates in a single step and one output register holds the pending result.
// Reset: synchronous, active low; returns to waiting for an 8-byte chunk header
// with running status and all accumulators cleared.
module midi_track_event_parser_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] stream_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // channel_number, first_data, second_data,
                                          // bend_value, delta_ticks, meta_type,
                                          // payload_length, payload_byte, end_of_track
    output logic [3:0]    m_axis_tuser,   // [3:0] kind
    output logic          m_axis_tlast    // last_payload
);

    mtep_pkg::t_phase                      r_phase, n_phase;
    logic [mtep_pkg::HDR_CNT_W-1:0]        r_hdr_cnt, n_hdr_cnt;
    mtep_pkg::t_varlen                     r_acc, n_acc;
    mtep_pkg::t_varlen                     r_delta, n_delta;
    logic [7:0]                            r_run, n_run;
    logic [7:0]                            r_status, n_status;
    logic [7:0]                            r_first, n_first;
    mtep_pkg::t_varlen                     r_remain, n_remain;
    logic [7:0]                            r_mtype, n_mtype;
    logic                                  r_out_valid, n_out_valid;
    mtep_pkg::t_result                     r_out, n_out;

    logic              accept;
    logic              have_res;
    mtep_pkg::t_result res;
    logic [7:0]        b;
    logic [7:0]        chan_status;
    logic [7:0]        chan_first;
    logic [7:0]        chan_second;
    logic              chan_emit;
    logic              done_event;
    mtep_pkg::t_varlen acc_next;
    mtep_pkg::t_varlen remain_dec;
    logic [3:0]        ctype;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;
    assign acc_next      = mtep_pkg::varlen_shift(r_acc, b);
    assign remain_dec    = (r_remain != '0) ? r_remain - 1'b1 : r_remain;
    assign ctype         = chan_status[7:4];

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_acc       = r_acc;
        n_delta     = r_delta;
        n_run       = r_run;
        n_status    = r_status;
        n_first     = r_first;
        n_remain    = r_remain;
        n_mtype     = r_mtype;
        have_res    = 1'b0;
        chan_emit   = 1'b0;
        chan_status = r_status;
        chan_first  = r_first;
        chan_second = 8'd0;
        done_event  = 1'b0;
        res                = '0;
        res.delta_ticks    = mtep_pkg::OUT_LEN_W'(r_delta);

        unique case (r_phase)
            mtep_pkg::PH_HEADER: begin
                if (r_hdr_cnt == mtep_pkg::HDR_CNT_W'(mtep_pkg::HDR_BYTES - 1)) begin
                    n_hdr_cnt = '0;
                    n_acc     = '0;
                    n_run     = 8'd0;
                    n_phase   = mtep_pkg::PH_DELTA;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 1'b1;
                end
            end
            mtep_pkg::PH_DELTA: begin
                n_acc = acc_next;
                if (!b[7]) begin
                    n_delta = acc_next;
                    n_acc   = '0;
                    n_phase = mtep_pkg::PH_STATUS;
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (!b[7]) begin
                    if (r_run == 8'd0) begin
                        n_phase = mtep_pkg::PH_DELTA;
                    end else begin
                        n_status    = r_run;
                        n_first     = b;
                        chan_status = r_run;
                        chan_first  = b;
                        if (r_run[7:4] == mtep_pkg::TYPE_PROGRAM ||
                            r_run[7:4] == mtep_pkg::TYPE_CHAN_PRS) begin
                            chan_emit = 1'b1;
                        end else begin
                            n_phase = mtep_pkg::PH_SECOND;
                        end
                    end
                end else begin
                    n_status = b;
                    if (b < mtep_pkg::ST_SYSEX) begin
                        n_run   = b;
                        n_phase = mtep_pkg::PH_FIRST;
                    end else begin
                        n_run   = 8'd0;
                        n_mtype = 8'd0;
                        if (b == mtep_pkg::ST_META) begin
                            n_phase = mtep_pkg::PH_MTYPE;
                        end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
                            n_phase = mtep_pkg::PH_LENGTH;
                        end else begin
                            n_phase = mtep_pkg::PH_SKIP;
                        end
                    end
                end
            end
            mtep_pkg::PH_FIRST: begin
                n_first    = b;
                chan_first = b;
                if (r_status[7:4] == mtep_pkg::TYPE_PROGRAM ||
                    r_status[7:4] == mtep_pkg::TYPE_CHAN_PRS) begin
                    chan_emit = 1'b1;
                end else begin
                    n_phase = mtep_pkg::PH_SECOND;
                end
            end
            mtep_pkg::PH_SECOND: begin
                chan_second = b;
                chan_emit   = 1'b1;
            end
            mtep_pkg::PH_MTYPE: begin
                n_mtype = b;
                n_acc   = '0;
                n_phase = mtep_pkg::PH_LENGTH;
            end
            mtep_pkg::PH_LENGTH: begin
                n_acc = acc_next;
                if (!b[7]) begin
                    have_res = 1'b1;
                    if (r_status == mtep_pkg::ST_META) begin
                        res.kind         = mtep_pkg::KIND_META;
                        res.meta_type    = r_mtype;
                        res.end_of_track = (r_mtype == mtep_pkg::META_EOT);
                    end else begin
                        res.kind = mtep_pkg::KIND_SYSEX;
                    end
                    res.payload_length = mtep_pkg::OUT_LEN_W'(acc_next);
                    n_remain = acc_next;
                    n_acc    = '0;
                    if (acc_next == '0) begin
                        done_event = 1'b1;
                    end else begin
                        n_phase = mtep_pkg::PH_PAYLOAD;
                    end
                end
            end
            mtep_pkg::PH_PAYLOAD: begin
                have_res         = 1'b1;
                res.kind         = mtep_pkg::KIND_PAYLOAD;
                res.payload_byte = b;
                n_remain         = remain_dec;
                if (remain_dec == '0) begin
                    res.last_payload = 1'b1;
                    done_event       = 1'b1;
                end
            end
            mtep_pkg::PH_SKIP: begin
                n_phase = mtep_pkg::PH_DELTA;
            end
            default: begin
                n_phase   = mtep_pkg::PH_HEADER;
                n_hdr_cnt = '0;
                n_acc     = '0;
                n_delta   = '0;
                n_run     = 8'd0;
                n_status  = 8'd0;
                n_first   = 8'd0;
                n_mtype   = 8'd0;
                n_remain  = '0;
            end
        endcase

        if (chan_emit) begin
            have_res           = 1'b1;
            res.kind           = ctype - mtep_pkg::TYPE_NOTE_OFF;
            res.channel_number = chan_status[3:0];
            res.first_data     = chan_first;
            res.second_data    = chan_second;
            if (ctype == mtep_pkg::TYPE_BEND) begin
                res.bend_value = ({8'd0, chan_second} << 7) | {8'd0, chan_first};
            end
            n_phase = mtep_pkg::PH_DELTA;
        end

        if (done_event) begin
            if (r_status == mtep_pkg::ST_META && r_mtype == mtep_pkg::META_EOT) begin
                n_phase   = mtep_pkg::PH_HEADER;
                n_hdr_cnt = '0;
                n_run     = 8'd0;
            end else begin
                n_phase = mtep_pkg::PH_DELTA;
            end
        end
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (accept && have_res) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mtep_pkg::PH_HEADER;
            r_hdr_cnt   <= '0;
            r_acc       <= '0;
            r_delta     <= '0;
            r_run       <= 8'd0;
            r_status    <= 8'd0;
            r_first     <= 8'd0;
            r_remain    <= '0;
            r_mtype     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_phase   <= n_phase;
                r_hdr_cnt <= n_hdr_cnt;
                r_acc     <= n_acc;
                r_delta   <= n_delta;
                r_run     <= n_run;
                r_status  <= n_status;
                r_first   <= n_first;
                r_remain  <= n_remain;
                r_mtype   <= n_mtype;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last_payload;
    assign m_axis_tdata  = {3'd0,
                            r_out.end_of_track,
                            r_out.payload_byte,
                            r_out.payload_length,
                            r_out.meta_type,
                            r_out.delta_ticks,
                            r_out.bend_value,
                            r_out.second_data,
                            r_out.first_data,
                            r_out.channel_number};

endmodule
